// ===== hdl/dlts_pkg.sv =====
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types, codes and the control store of the level traversal scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

    localparam int MAX_LEVELS_DFLT = 16;

    localparam int ACTION_W = 2;
    localparam int PAGE_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int KIND_W   = 2;
    localparam int LAYER_W  = 4;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W   = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL_B = 1'd1;

    // input actions
    localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PAIR  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COUNT = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REQ = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FWD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIN = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PAIR  = 2'd1,
        PH_COUNT = 2'd2
    } t_phase;

    // control word fields
    typedef enum logic [1:0] {EM_NONE, EM_REQ, EM_FWD, EM_FIN} t_emit;
    typedef enum logic [1:0] {RD_NONE, RD_DEPTH_M1, RD_AUTO} t_rd;
    typedef enum logic [1:0] {WR_NONE, WR_ROOT, WR_NEST, WR_BUMP} t_wr;
    typedef enum logic [1:0] {DP_HOLD, DP_ONE, DP_INC, DP_DEC} t_dop;
    typedef enum logic [1:0] {DS_HOLD, DS_SET, DS_CLR} t_dsop;
    typedef enum logic [1:0] {PO_HOLD, PO_IDLE, PO_PAIR, PO_COUNT} t_phop;
    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_DISPATCH, C_SHALLOW, C_DEPTH0, C_DESC, C_EQ, C_CNT0
    } t_cond;

    typedef struct packed {
        t_emit             emit;
        t_rd               rd;
        t_wr               wr;
        t_dop              dop;
        t_dsop             dsop;
        t_phop             phop;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // program steps
    localparam logic [STEP_W-1:0] ST_WAIT      = 4'd0;
    localparam logic [STEP_W-1:0] ST_START     = 4'd1;
    localparam logic [STEP_W-1:0] ST_PAIR      = 4'd2;
    localparam logic [STEP_W-1:0] ST_CLIMB     = 4'd3;
    localparam logic [STEP_W-1:0] ST_CLIMB_WB  = 4'd4;
    localparam logic [STEP_W-1:0] ST_ADV       = 4'd5;
    localparam logic [STEP_W-1:0] ST_ADV_RD    = 4'd6;
    localparam logic [STEP_W-1:0] ST_CMP       = 4'd7;
    localparam logic [STEP_W-1:0] ST_OPEN      = 4'd8;
    localparam logic [STEP_W-1:0] ST_REQ       = 4'd9;
    localparam logic [STEP_W-1:0] ST_FIN       = 4'd10;
    localparam logic [STEP_W-1:0] ST_COUNT_IN  = 4'd11;
    localparam logic [STEP_W-1:0] ST_NEST      = 4'd12;
    localparam logic [STEP_W-1:0] ST_SET_COUNT = 4'd13;

    // control store
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl cw;
        cw.emit   = EM_NONE;
        cw.rd     = RD_NONE;
        cw.wr     = WR_NONE;
        cw.dop    = DP_HOLD;
        cw.dsop   = DS_HOLD;
        cw.phop   = PO_HOLD;
        cw.cond   = C_ALWAYS;
        cw.target = ST_WAIT;
        unique case (step)
            ST_WAIT: begin
                cw.cond = C_DISPATCH;
            end
            ST_START: begin
                cw.wr     = WR_ROOT;
                cw.dop    = DP_ONE;
                cw.dsop   = DS_SET;
                cw.target = ST_ADV;
            end
            ST_PAIR: begin
                cw.emit   = EM_FWD;
                cw.cond   = C_SHALLOW;
                cw.target = ST_SET_COUNT;
            end
            ST_CLIMB: begin
                cw.rd   = RD_DEPTH_M1;
                cw.dop  = DP_DEC;
                cw.cond = C_NEXT;
            end
            ST_CLIMB_WB: begin
                cw.wr   = WR_BUMP;
                cw.dsop = DS_CLR;
                cw.cond = C_NEXT;
            end
            ST_ADV: begin
                cw.cond   = C_DEPTH0;
                cw.target = ST_FIN;
            end
            ST_ADV_RD: begin
                cw.rd     = RD_AUTO;
                cw.cond   = C_DESC;
                cw.target = ST_REQ;
            end
            ST_CMP: begin
                cw.cond   = C_EQ;
                cw.target = ST_CLIMB;
            end
            ST_OPEN: begin
                cw.dop    = DP_INC;
                cw.dsop   = DS_SET;
                cw.target = ST_ADV;
            end
            ST_REQ: begin
                cw.emit = EM_REQ;
                cw.phop = PO_PAIR;
            end
            ST_FIN: begin
                cw.emit = EM_FIN;
                cw.phop = PO_IDLE;
            end
            ST_COUNT_IN: begin
                cw.cond   = C_CNT0;
                cw.target = ST_CLIMB;
            end
            ST_NEST: begin
                cw.wr     = WR_NEST;
                cw.dop    = DP_INC;
                cw.dsop   = DS_SET;
                cw.target = ST_ADV;
            end
            ST_SET_COUNT: begin
                cw.phop = PO_COUNT;
            end
            default: begin
                cw.target = ST_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== hdl/dlts_ram.sv =====
// ----------------------------------------------------------------------------
// dlts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dlts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dfs_level_traversal_scheduler.sv =====
// ----------------------------------------------------------------------------
// dfs_level_traversal_scheduler
// Depth-first, level-by-level tree join scheduler driven by a microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one word per memory response:
//   start join, node pair returned, or intersect count returned. A word that
//   does not fit the current phase is taken and dropped without a result.
//   Output channel (o_valid / i_stall) carries read requests, forwarded pairs
//   and the finish word; o_last marks the final word caused by an input.
//   Configuration: i_cfg_we writes max_level_a (index 0) or max_level_b
//   (index 1); write only while the join is idle.
//   A word that yields a result runs through the microprogram steps, with more
//   steps per level climbed back up; the read of the level RAM is registered.
//   o_stall is high while the sequencer is busy with the previous word.
//   Reset (i_rst_n low, synchronous) returns to idle with depth 1; the level
//   RAM is not cleared, every entry is written before it is read.
//   A stalled receiver freezes the sequencer at its next emitting step; the
//   held output word stays unchanged until taken.
// ----------------------------------------------------------------------------
module dfs_level_traversal_scheduler #(
    parameter int MAX_LEVELS = dlts_pkg::MAX_LEVELS_DFLT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [dlts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dlts_pkg::CFG_W-1:0]      i_cfg_data,
    // input words
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [dlts_pkg::ACTION_W-1:0]   i_action,
    input  logic [dlts_pkg::PAGE_W-1:0]     i_page_a,
    input  logic [dlts_pkg::PAGE_W-1:0]     i_page_b,
    input  logic [dlts_pkg::COUNT_W-1:0]    i_pair_count,
    // output words
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [dlts_pkg::KIND_W-1:0]     o_kind,
    output logic [dlts_pkg::LAYER_W-1:0]    o_layer,
    output logic [dlts_pkg::COUNT_W-1:0]    o_pointer,
    output logic [dlts_pkg::PAGE_W-1:0]     o_out_page_a,
    output logic [dlts_pkg::PAGE_W-1:0]     o_out_page_b,
    output logic                            o_last
);

    localparam int DW = $clog2(MAX_LEVELS);
    localparam int CW = dlts_pkg::COUNT_W;
    localparam int MW = 2 * CW;
    localparam logic [7:0] TOP_LEVEL = 8'(MAX_LEVELS - 1);

    // configuration registers
    logic [dlts_pkg::CFG_W-1:0] r_max_a, r_max_b;

    // sequencer and datapath state
    logic [dlts_pkg::STEP_W-1:0] r_upc, n_upc;
    logic [DW-1:0]               r_depth, n_depth;
    logic                        r_desc, n_desc;
    dlts_pkg::t_phase            r_phase, n_phase;
    logic [dlts_pkg::PAGE_W-1:0] r_pa, r_pb;
    logic [CW-1:0]               r_cnt;

    // output register
    logic                          r_o_valid, n_o_valid;
    logic [dlts_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [dlts_pkg::LAYER_W-1:0]  r_layer, n_layer;
    logic [CW-1:0]                 r_pointer, n_pointer;
    logic [dlts_pkg::PAGE_W-1:0]   r_opa, n_opa, r_opb, n_opb;
    logic                          r_last, n_last;

    dlts_pkg::t_ctrl w_cw;
    logic            w_accept, w_emit, w_hold, w_go, w_deep, w_taken;
    logic [dlts_pkg::CFG_W-1:0] w_max;
    logic [7:0]      w_lim;
    logic [DW-1:0]   w_depth_m1;

    // level RAM: {count, pointer} per level
    logic            w_we, w_re;
    logic [DW-1:0]   w_waddr, w_raddr;
    logic [MW-1:0]   w_wdata, w_rdata;
    logic [CW-1:0]   w_rd_cnt, w_rd_ptr;

    dlts_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_LEVELS)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_cnt = w_rdata[MW-1:CW];
    assign w_rd_ptr = w_rdata[CW-1:0];

    // traversal depth: larger tree depth, clamped to [1, MAX_LEVELS-1]
    always_comb begin
        w_max = (r_max_a > r_max_b) ? r_max_a : r_max_b;
        if (w_max == '0) begin
            w_lim = 8'd1;
        end else if ({4'b0, w_max} > TOP_LEVEL) begin
            w_lim = TOP_LEVEL;
        end else begin
            w_lim = {4'b0, w_max};
        end
    end

    assign w_deep     = (8'(r_depth) >= w_lim);
    assign w_depth_m1 = r_depth - DW'(1);

    // control word of the current step
    assign w_cw     = dlts_pkg::ucode(r_upc);
    assign o_stall  = (r_upc != dlts_pkg::ST_WAIT);
    assign w_accept = i_valid && !o_stall;
    assign w_emit   = (w_cw.emit != dlts_pkg::EM_NONE);
    assign w_taken  = r_o_valid && !i_stall;
    // an emitting step waits for room in the output register
    assign w_hold   = w_emit && r_o_valid && i_stall;
    assign w_go     = !w_hold;

    // level RAM ports
    always_comb begin
        w_re    = w_go && (w_cw.rd != dlts_pkg::RD_NONE);
        w_raddr = r_depth;
        if (w_cw.rd == dlts_pkg::RD_DEPTH_M1 ||
            (w_cw.rd == dlts_pkg::RD_AUTO && r_desc)) begin
            w_raddr = w_depth_m1;
        end
        w_we    = w_go && (w_cw.wr != dlts_pkg::WR_NONE);
        w_waddr = r_depth;
        w_wdata = {w_rd_cnt, w_rd_ptr + CW'(1)};
        case (w_cw.wr)
            dlts_pkg::WR_ROOT: begin
                w_waddr = '0;
                w_wdata = {CW'(1), CW'(0)};
            end
            dlts_pkg::WR_NEST: begin
                w_wdata = {r_cnt, CW'(0)};
            end
            default: begin
                w_wdata = {w_rd_cnt, w_rd_ptr + CW'(1)};
            end
        endcase
    end

    // step counter and datapath next state
    always_comb begin
        logic taken;
        taken   = 1'b0;
        n_upc   = r_upc;
        n_depth = r_depth;
        n_desc  = r_desc;
        n_phase = r_phase;

        case (w_cw.cond)
            dlts_pkg::C_ALWAYS:  taken = 1'b1;
            dlts_pkg::C_SHALLOW: taken = !w_deep;
            dlts_pkg::C_DEPTH0:  taken = (r_depth == '0);
            dlts_pkg::C_DESC:    taken = r_desc;
            dlts_pkg::C_EQ:      taken = (w_rd_ptr == w_rd_cnt);
            dlts_pkg::C_CNT0:    taken = (r_cnt == '0);
            default:             taken = 1'b0;
        endcase

        if (w_go) begin
            if (w_cw.cond == dlts_pkg::C_DISPATCH) begin
                // pick the handler for an in-phase word; drop the rest
                n_upc = dlts_pkg::ST_WAIT;
                if (w_accept) begin
                    if (i_action == dlts_pkg::ACT_START && r_phase == dlts_pkg::PH_IDLE) begin
                        n_upc = dlts_pkg::ST_START;
                    end else if (i_action == dlts_pkg::ACT_PAIR &&
                                 r_phase == dlts_pkg::PH_PAIR) begin
                        n_upc = dlts_pkg::ST_PAIR;
                    end else if (i_action == dlts_pkg::ACT_COUNT &&
                                 r_phase == dlts_pkg::PH_COUNT) begin
                        n_upc = dlts_pkg::ST_COUNT_IN;
                    end
                end
            end else if (taken) begin
                n_upc = w_cw.target;
            end else begin
                n_upc = r_upc + dlts_pkg::STEP_W'(1);
            end

            case (w_cw.dop)
                dlts_pkg::DP_ONE: n_depth = DW'(1);
                dlts_pkg::DP_INC: n_depth = r_depth + DW'(1);
                dlts_pkg::DP_DEC: n_depth = w_depth_m1;
                default:          n_depth = r_depth;
            endcase

            case (w_cw.dsop)
                dlts_pkg::DS_SET: n_desc = 1'b1;
                dlts_pkg::DS_CLR: n_desc = 1'b0;
                default:          n_desc = r_desc;
            endcase

            case (w_cw.phop)
                dlts_pkg::PO_IDLE:  n_phase = dlts_pkg::PH_IDLE;
                dlts_pkg::PO_PAIR:  n_phase = dlts_pkg::PH_PAIR;
                dlts_pkg::PO_COUNT: n_phase = dlts_pkg::PH_COUNT;
                default:            n_phase = r_phase;
            endcase
        end
    end

    // output word
    always_comb begin
        n_o_valid = r_o_valid && !w_taken;
        n_kind    = r_kind;
        n_layer   = r_layer;
        n_pointer = r_pointer;
        n_opa     = r_opa;
        n_opb     = r_opb;
        n_last    = r_last;
        if (w_go && w_emit) begin
            n_o_valid = 1'b1;
            n_pointer = '0;
            n_opa     = '0;
            n_opb     = '0;
            n_last    = 1'b1;
            n_layer   = '0;
            case (w_cw.emit)
                dlts_pkg::EM_REQ: begin
                    n_kind    = dlts_pkg::KIND_REQ;
                    n_layer   = dlts_pkg::LAYER_W'(w_depth_m1);
                    n_pointer = w_rd_ptr;
                end
                dlts_pkg::EM_FWD: begin
                    n_kind  = dlts_pkg::KIND_FWD;
                    n_layer = dlts_pkg::LAYER_W'(r_depth);
                    n_opa   = r_pa;
                    n_opb   = r_pb;
                    // at the deepest level the climb follows in the same item
                    n_last  = !w_deep;
                end
                default: begin
                    n_kind = dlts_pkg::KIND_FIN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_a   <= dlts_pkg::CFG_W'(1);
            r_max_b   <= dlts_pkg::CFG_W'(1);
            r_upc     <= dlts_pkg::ST_WAIT;
            r_depth   <= DW'(1);
            r_desc    <= 1'b1;
            r_phase   <= dlts_pkg::PH_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dlts_pkg::REG_MAX_LEVEL_A: r_max_a <= i_cfg_data;
                    dlts_pkg::REG_MAX_LEVEL_B: r_max_b <= i_cfg_data;
                endcase
            end
            r_upc     <= n_upc;
            r_depth   <= n_depth;
            r_desc    <= n_desc;
            r_phase   <= n_phase;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pa  <= i_page_a;
            r_pb  <= i_page_b;
            r_cnt <= i_pair_count;
        end
        r_kind    <= n_kind;
        r_layer   <= n_layer;
        r_pointer <= n_pointer;
        r_opa     <= n_opa;
        r_opb     <= n_opb;
        r_last    <= n_last;
    end

    assign o_valid      = r_o_valid;
    assign o_kind       = r_kind;
    assign o_layer      = r_layer;
    assign o_pointer    = r_pointer;
    assign o_out_page_a = r_opa;
    assign o_out_page_b = r_opb;
    assign o_last       = r_last;

endmodule
